// ----- rtl/core/cbm_pkg.sv -----
// Shared types, constants and ARX helper functions for the block MAC.
// Depends on nothing; every other file of the core but cbm_stream_if imports it.
`default_nettype none

package cbm_pkg;

    // Sizes and defaults
    localparam int unsigned CBM_ROUNDS      = 12;
    localparam int unsigned CBM_QUEUE_DEPTH = 2;
    localparam int unsigned CBM_WORD_W      = 32;
    localparam int unsigned CBM_CFG_IDX_W   = 8;

    // Rotation amounts of one round
    localparam int unsigned CBM_ROT_A = 5;
    localparam int unsigned CBM_ROT_B = 16;
    localparam int unsigned CBM_ROT_C = 8;
    localparam int unsigned CBM_ROT_D = 13;
    localparam int unsigned CBM_ROT_E = 7;

    // Reduction polynomial for the key doubling
    localparam logic [127:0] CBM_DBL_POLY = 128'h87;

    // Configuration register indexes
    localparam logic [CBM_CFG_IDX_W-1:0] CBM_REG_KEY_WORD0 = CBM_CFG_IDX_W'(0);
    localparam logic [CBM_CFG_IDX_W-1:0] CBM_REG_KEY_WORD1 = CBM_CFG_IDX_W'(1);
    localparam logic [CBM_CFG_IDX_W-1:0] CBM_REG_KEY_WORD2 = CBM_CFG_IDX_W'(2);
    localparam logic [CBM_CFG_IDX_W-1:0] CBM_REG_KEY_WORD3 = CBM_CFG_IDX_W'(3);

    // Four 32-bit words, word 0 least significant
    typedef logic [3:0][CBM_WORD_W-1:0] cbm_state_t;

    typedef struct packed {
        logic [CBM_WORD_W-1:0] msg_word3;
        logic [CBM_WORD_W-1:0] msg_word2;
        logic [CBM_WORD_W-1:0] msg_word1;
        logic [CBM_WORD_W-1:0] msg_word0;
        logic                  last_block;
    } cbm_msg_t;

    typedef struct packed {
        logic [CBM_WORD_W-1:0] tag_word3;
        logic [CBM_WORD_W-1:0] tag_word2;
        logic [CBM_WORD_W-1:0] tag_word1;
        logic [CBM_WORD_W-1:0] tag_word0;
    } cbm_tag_t;

    typedef struct packed {
        logic [CBM_CFG_IDX_W-1:0] index;
        logic [CBM_WORD_W-1:0]    wdata;
    } cbm_cfg_t;

    // Queue entry: classified block
    typedef struct packed {
        cbm_state_t block;
        logic       last;
        logic       first;
    } cbm_entry_t;

    function automatic logic [CBM_WORD_W-1:0] cbm_rotl(
        input logic [CBM_WORD_W-1:0] x,
        input int unsigned           b
    );
        return (x << b) | (x >> (CBM_WORD_W - b));
    endfunction

    // One ARX round of the permutation
    function automatic cbm_state_t cbm_round(input cbm_state_t s);
        logic [CBM_WORD_W-1:0] v0;
        logic [CBM_WORD_W-1:0] v1;
        logic [CBM_WORD_W-1:0] v2;
        logic [CBM_WORD_W-1:0] v3;
        cbm_state_t            r;
        v0 = s[0] + s[1];
        v1 = cbm_rotl(s[1], CBM_ROT_A) ^ v0;
        v0 = cbm_rotl(v0, CBM_ROT_B);
        v2 = s[2] + s[3];
        v3 = cbm_rotl(s[3], CBM_ROT_C) ^ v2;
        v0 = v0 + v3;
        v3 = cbm_rotl(v3, CBM_ROT_D) ^ v0;
        v2 = v2 + v1;
        v1 = cbm_rotl(v1, CBM_ROT_E) ^ v2;
        v2 = cbm_rotl(v2, CBM_ROT_B);
        r[0] = v0;
        r[1] = v1;
        r[2] = v2;
        r[3] = v3;
        return r;
    endfunction

    // Key times x in GF(2^128)
    function automatic cbm_state_t cbm_double(input cbm_state_t k);
        logic [127:0] kf;
        logic [127:0] d;
        kf = k;
        d  = {kf[126:0], 1'b0} ^ (kf[127] ? CBM_DBL_POLY : 128'h0);
        return d;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/cbm_stream_if.sv -----
// Valid/ready channel carrying one payload beat per handshake.
// Payload type is a parameter; depends on nothing else.
`default_nettype none

interface cbm_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/cbm_front.sv -----
// Front end: key registers, message tracking and block classification.
// Depends on cbm_pkg and cbm_stream_if.
`default_nettype none

module cbm_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    cbm_stream_if.sink         msg,
    cbm_stream_if.sink         cfg,
    cbm_stream_if.source       queue,
    output cbm_pkg::cbm_state_t key
);
    import cbm_pkg::*;

    cbm_state_t key_reg;
    cbm_state_t key_next;
    logic       mid_reg;
    logic       mid_next;
    cbm_entry_t entry;

    // Register writes are always taken
    assign cfg.ready = 1'b1;

    always_comb
    begin
        key_next = key_reg;
        if (cfg.valid)
        begin
            unique case (cfg.data.index)
                CBM_REG_KEY_WORD0: key_next[0] = cfg.data.wdata;
                CBM_REG_KEY_WORD1: key_next[1] = cfg.data.wdata;
                CBM_REG_KEY_WORD2: key_next[2] = cfg.data.wdata;
                CBM_REG_KEY_WORD3: key_next[3] = cfg.data.wdata;
                default:           key_next = key_reg;
            endcase
        end
    end

    // Tag each block as first of its message or not; pass its words and last flag on
    always_comb
    begin
        entry.block[0] = msg.data.msg_word0;
        entry.block[1] = msg.data.msg_word1;
        entry.block[2] = msg.data.msg_word2;
        entry.block[3] = msg.data.msg_word3;
        entry.last     = msg.data.last_block;
        entry.first    = !mid_reg;
        mid_next       = mid_reg;
        if (msg.valid && queue.ready)
        begin
            mid_next = !msg.data.last_block;
        end
    end

    assign queue.valid = msg.valid;
    assign queue.data  = entry;
    assign msg.ready   = queue.ready;
    assign key         = key_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
            mid_reg <= 1'b0;
        end
        else
        begin
            key_reg <= key_next;
            mid_reg <= mid_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/cbm_fifo.sv -----
// Short block queue between front and back end.
// Depends on cbm_pkg and cbm_stream_if.
`default_nettype none

module cbm_fifo #(
    parameter int unsigned DEPTH = cbm_pkg::CBM_QUEUE_DEPTH
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    cbm_stream_if.sink   push,
    cbm_stream_if.source pop
);
    import cbm_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    cbm_entry_t       mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             do_push;
    logic             do_pop;

    assign push.ready = (cnt_reg != FULL_CNT);
    assign pop.valid  = (cnt_reg != '0);
    assign pop.data   = mem_reg[rd_ptr_reg];
    assign do_push    = push.valid && push.ready;
    assign do_pop     = pop.valid && pop.ready;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        priority if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
        else
        begin
            cnt_next = cnt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store payload beats
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push.data;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/cbm_back.sv -----
// Back end: chain value, round engine (one round per cycle) and tag register.
// Depends on cbm_pkg and cbm_stream_if.
`default_nettype none

module cbm_back #(
    parameter int unsigned ROUNDS = cbm_pkg::CBM_ROUNDS
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire cbm_pkg::cbm_state_t key,
    cbm_stream_if.sink               queue,
    cbm_stream_if.source             tag
);
    import cbm_pkg::*;

    localparam int unsigned CNT_W = $clog2(ROUNDS + 1);
    localparam logic [CNT_W-1:0] LAST_RND = CNT_W'(ROUNDS);

    cbm_state_t       state_reg;
    cbm_state_t       state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             busy_reg;
    logic             busy_next;
    logic             last_reg;
    logic             last_next;
    logic             tag_valid_reg;
    logic             tag_valid_next;
    cbm_tag_t         tag_data_reg;
    cbm_tag_t         tag_data_next;

    cbm_state_t k1;
    cbm_state_t base;
    cbm_state_t seed;
    cbm_state_t final_v;
    logic       done;
    logic       tag_free;
    logic       retire;
    logic       load;

    assign k1 = cbm_double(key);

    // Retire the current block and pick up the next one in the same cycle
    assign done     = busy_reg && (cnt_reg == LAST_RND);
    assign tag_free = !tag_valid_reg || tag.ready;
    assign retire   = done && (!last_reg || tag_free);
    assign queue.ready = !busy_reg || retire;
    assign load     = queue.valid && queue.ready;

    // Absorb the block: key at message start, k1 on the last block
    always_comb
    begin
        base    = queue.data.first ? key : state_reg;
        seed    = base ^ queue.data.block ^ (queue.data.last ? k1 : '0);
        final_v = state_reg ^ k1;
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        last_next  = last_reg;
        priority if (load)
        begin
            state_next = cbm_round(seed);
            cnt_next   = CNT_W'(1);
            busy_next  = 1'b1;
            last_next  = queue.data.last;
        end
        else if (retire)
        begin
            busy_next = 1'b0;
        end
        else if (busy_reg && !done)
        begin
            state_next = cbm_round(state_reg);
            cnt_next   = cnt_reg + 1'b1;
        end
        else
        begin
            busy_next = busy_reg;
        end
    end

    // Hold the tag until the sink takes it
    always_comb
    begin
        tag_valid_next = tag_valid_reg;
        tag_data_next  = tag_data_reg;
        priority if (retire && last_reg)
        begin
            tag_valid_next          = 1'b1;
            tag_data_next.tag_word0 = final_v[0];
            tag_data_next.tag_word1 = final_v[1];
            tag_data_next.tag_word2 = final_v[2];
            tag_data_next.tag_word3 = final_v[3];
        end
        else if (tag.ready)
        begin
            tag_valid_next = 1'b0;
        end
        else
        begin
            tag_valid_next = tag_valid_reg;
        end
    end

    assign tag.valid = tag_valid_reg;
    assign tag.data  = tag_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            busy_reg      <= 1'b0;
            last_reg      <= 1'b0;
            tag_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            busy_reg      <= busy_next;
            last_reg      <= last_next;
            tag_valid_reg <= tag_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        state_reg    <= state_next;
        tag_data_reg <= tag_data_next;
    end

`ifndef ASSERT_OFF
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (cnt_reg != '0) && (cnt_reg <= LAST_RND))
        else $error("round counter out of range while busy");

    a_load_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        (load && busy_reg) |-> (cnt_reg == LAST_RND))
        else $error("block loaded before permutation finished");

    a_tag_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(tag_valid_reg) |-> $past(busy_reg && last_reg && done))
        else $error("tag raised without a finished last block");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/chaskey_block_mac.sv -----
// Chaskey block MAC top level: front end, block queue and round engine.
// The single-round engine loop takes a new block only as it retires the last one;
// blocks of one message chain through it. Up to QUEUE_DEPTH blocks wait ahead.
// Reset (rst_n, async low): key zero, no message open, queue and tag empty.
`default_nettype none

module chaskey_block_mac #(
    parameter int unsigned ROUNDS      = cbm_pkg::CBM_ROUNDS,
    parameter int unsigned QUEUE_DEPTH = cbm_pkg::CBM_QUEUE_DEPTH
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    cbm_stream_if.sink   msg,
    cbm_stream_if.sink   cfg,
    cbm_stream_if.source tag
);
    import cbm_pkg::*;

    cbm_state_t key;

    cbm_stream_if #(.payload_t(cbm_entry_t)) front_q ();
    cbm_stream_if #(.payload_t(cbm_entry_t)) back_q ();

    cbm_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .msg   (msg),
        .cfg   (cfg),
        .queue (front_q),
        .key   (key)
    );

    cbm_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (front_q),
        .pop   (back_q)
    );

    cbm_back #(
        .ROUNDS (ROUNDS)
    ) u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .key   (key),
        .queue (back_q),
        .tag   (tag)
    );

endmodule

`default_nettype wire

// ----- dv/chaskey_block_mac_tb.sv -----
// Self-checking testbench for chaskey_block_mac: directed table, then random messages.
// Tags are predicted by an in-bench Chaskey model; depends on cbm_pkg and cbm_stream_if.
`default_nettype none

module chaskey_block_mac_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import cbm_pkg::*;

    // Idle cycles before a key write: engine drain with a full queue, plus margin
    localparam int unsigned SETTLE_CYCLES   = (CBM_QUEUE_DEPTH + 2) * (CBM_ROUNDS + 1) + 4;
    localparam int unsigned STALL_LIMIT     = 5000;
    localparam int unsigned BLOCKS_PER_SEG  = 165;
    localparam int unsigned MAX_SHOWN       = 10;
    localparam logic [127:0] DBL_REDUCE     = 128'h87;

    localparam logic [CBM_CFG_IDX_W-1:0] KEY_REGS [4] = '{
        CBM_REG_KEY_WORD0, CBM_REG_KEY_WORD1, CBM_REG_KEY_WORD2, CBM_REG_KEY_WORD3
    };

    typedef enum logic [1:0] {
        ROW_BLOCK,
        ROW_KEY
    } row_kind_t;

    // One table row: a message beat, or a key register write (value in data[31:0])
    typedef struct packed {
        row_kind_t                kind;
        logic [CBM_CFG_IDX_W-1:0] reg_idx;
        logic [127:0]             data;
        logic                     last;
        logic                     known;
        cbm_tag_t                 known_tag;
    } stim_row_t;

    localparam stim_row_t DIRECTED_ROWS [19] = '{
        // zero key, zero block: every ARX step keeps zero, so the tag is zero
        '{ROW_BLOCK, CBM_REG_KEY_WORD0, 128'h0, 1'b1, 1'b1, 128'h0},
        '{ROW_BLOCK, CBM_REG_KEY_WORD0, {4{32'hffff_ffff}}, 1'b1, 1'b0, 128'h0},
        // three-block message
        '{ROW_BLOCK, CBM_REG_KEY_WORD0, 128'h80000000_00000000_00000000_00000001,
          1'b0, 1'b0, 128'h0},
        '{ROW_BLOCK, CBM_REG_KEY_WORD0, {4{32'hffff_ffff}}, 1'b0, 1'b0, 128'h0},
        '{ROW_BLOCK, CBM_REG_KEY_WORD0, 128'h0, 1'b1, 1'b0, 128'h0},
        // all-ones key: doubling needs the reduction
        '{ROW_KEY, CBM_REG_KEY_WORD0, 128'hffff_ffff, 1'b0, 1'b0, 128'h0},
        '{ROW_KEY, CBM_REG_KEY_WORD1, 128'hffff_ffff, 1'b0, 1'b0, 128'h0},
        '{ROW_KEY, CBM_REG_KEY_WORD2, 128'hffff_ffff, 1'b0, 1'b0, 128'h0},
        '{ROW_KEY, CBM_REG_KEY_WORD3, 128'hffff_ffff, 1'b0, 1'b0, 128'h0},
        '{ROW_BLOCK, CBM_REG_KEY_WORD0, 128'h0, 1'b1, 1'b0, 128'h0},
        '{ROW_BLOCK, CBM_REG_KEY_WORD0, {4{32'hffff_ffff}}, 1'b1, 1'b0, 128'h0},
        // key changed between the blocks of one message
        '{ROW_BLOCK, CBM_REG_KEY_WORD0, 128'h01234567_89abcdef_fedcba98_76543210,
          1'b0, 1'b0, 128'h0},
        '{ROW_KEY, CBM_REG_KEY_WORD3, 128'h0, 1'b0, 1'b0, 128'h0},
        '{ROW_BLOCK, CBM_REG_KEY_WORD0, 128'hfedcba98_76543210_01234567_89abcdef,
          1'b1, 1'b0, 128'h0},
        '{ROW_KEY, CBM_REG_KEY_WORD1, 128'h5555_5555, 1'b0, 1'b0, 128'h0},
        '{ROW_KEY, CBM_REG_KEY_WORD2, 128'haaaa_aaaa, 1'b0, 1'b0, 128'h0},
        '{ROW_BLOCK, CBM_REG_KEY_WORD0, {4{32'h5555_5555}}, 1'b0, 1'b0, 128'h0},
        '{ROW_KEY, CBM_REG_KEY_WORD0, 128'h0, 1'b0, 1'b0, 128'h0},
        '{ROW_BLOCK, CBM_REG_KEY_WORD0, {4{32'haaaa_aaaa}}, 1'b1, 1'b0, 128'h0}
    };

    logic clk = 1'b0;
    logic rst_n;

    cbm_stream_if #(.payload_t(cbm_msg_t)) msg_if ();
    cbm_stream_if #(.payload_t(cbm_cfg_t)) cfg_if ();
    cbm_stream_if #(.payload_t(cbm_tag_t)) tag_if ();

    chaskey_block_mac dut (
        .clk   (clk),
        .rst_n (rst_n),
        .msg   (msg_if),
        .cfg   (cfg_if),
        .tag   (tag_if)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // MAC model state
    cbm_state_t key_model   = '0;
    cbm_state_t chain_model = '0;
    bit         mid_model   = 1'b0;

    cbm_tag_t   pending_tags[$];
    int unsigned err_count    = 0;
    int unsigned src_idle_pct = 29;
    int unsigned snk_idle_pct = 66;

    // Typed-in tag that travels alongside the current message beat
    bit       typed_valid = 1'b0;
    cbm_tag_t typed_tag   = '0;

    function automatic logic [31:0] rol32(input logic [31:0] x, input int unsigned n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic cbm_state_t arx_permute(input cbm_state_t v);
        cbm_state_t s;
        s = v;
        for (int r = 0; r < CBM_ROUNDS; r++)
        begin
            s[0] = s[0] + s[1]; s[1] = rol32(s[1], 5) ^ s[0]; s[0] = rol32(s[0], 16);
            s[2] = s[2] + s[3]; s[3] = rol32(s[3], 8) ^ s[2];
            s[0] = s[0] + s[3]; s[3] = rol32(s[3], 13) ^ s[0];
            s[2] = s[2] + s[1]; s[1] = rol32(s[1], 7) ^ s[2]; s[2] = rol32(s[2], 16);
        end
        return s;
    endfunction

    // Absorb one block into the chain; a last block yields the tag
    function automatic void mac_absorb(input cbm_msg_t b, output bit made, output cbm_tag_t t);
        cbm_state_t   blk;
        logic [127:0] k;
        logic [127:0] k1;
        blk = {b.msg_word3, b.msg_word2, b.msg_word1, b.msg_word0};
        if (!mid_model)
            chain_model = key_model;
        chain_model = chain_model ^ blk;
        made = b.last_block;
        t = '0;
        if (!b.last_block)
        begin
            chain_model = arx_permute(chain_model);
            mid_model = 1'b1;
        end
        else
        begin
            k  = key_model;
            k1 = {k[126:0], 1'b0} ^ (k[127] ? DBL_REDUCE : 128'h0);
            chain_model = arx_permute(chain_model ^ k1) ^ k1;
            t = chain_model;
            mid_model = 1'b0;
        end
    endfunction

    function automatic void note_error(input string msg);
        err_count++;
        if (err_count <= MAX_SHOWN)
            $display("%0t: %s", $realtime, msg);
    endfunction

    // Mostly random words, with a share of all-zero, all-one and one-hot words
    function automatic logic [31:0] rand_word();
        case ($urandom_range(9))
            0: return 32'h0;
            1: return 32'hffff_ffff;
            2: return 32'h1 << $urandom_range(31);
            default: return $urandom;
        endcase
    endfunction

    // Watch every beat at the rising edge: track keys, predict tags, check tags
    always @(posedge clk)
    begin
        bit         made;
        cbm_tag_t   fresh;
        cbm_state_t want;
        cbm_state_t got;
        if (cfg_if.valid && cfg_if.ready)
        begin
            case (cfg_if.data.index)
                CBM_REG_KEY_WORD0: key_model[0] = cfg_if.data.wdata;
                CBM_REG_KEY_WORD1: key_model[1] = cfg_if.data.wdata;
                CBM_REG_KEY_WORD2: key_model[2] = cfg_if.data.wdata;
                CBM_REG_KEY_WORD3: key_model[3] = cfg_if.data.wdata;
                default: ;
            endcase
        end
        if (msg_if.valid && msg_if.ready)
        begin
            mac_absorb(msg_if.data, made, fresh);
            if (made)
                pending_tags.push_back(typed_valid ? typed_tag : fresh);
        end
        if (tag_if.valid && tag_if.ready)
        begin
            if (pending_tags.size() == 0)
                note_error($sformatf("tag beat with no tag pending: %h", tag_if.data));
            else
            begin
                want = pending_tags.pop_front();
                got  = tag_if.data;
                for (int w = 0; w < 4; w++)
                    if (got[w] !== want[w])
                        note_error($sformatf("tag_word%0d: expected %h, got %h",
                                             w, want[w], got[w]));
            end
        end
    end

    // Tag receiver: stall at random per the current idle share
    initial
    begin
        tag_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            tag_if.ready = ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // End the run after too many cycles with no beat on any channel
    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((msg_if.valid && msg_if.ready) || (cfg_if.valid && cfg_if.ready)
                || (tag_if.valid && tag_if.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    // Send one block; hold valid until the beat is taken. Call at the falling edge.
    task automatic send_block(input cbm_msg_t b, input bit typed, input cbm_tag_t typed_val);
        while ($urandom_range(99) < src_idle_pct)
        begin
            msg_if.valid = 1'b0;
            @(negedge clk);
        end
        msg_if.data  = b;
        typed_valid  = typed;
        typed_tag    = typed_val;
        msg_if.valid = 1'b1;
        do
            @(posedge clk);
        while (!msg_if.ready);
        @(negedge clk);
    endtask

    task automatic write_key(input logic [CBM_CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_if.data  = '{index: idx, wdata: val};
        cfg_if.valid = 1'b1;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        @(negedge clk);
        cfg_if.valid = 1'b0;
    endtask

    // Drop valid, drain pending tags, then let the engine finish any open block
    task automatic settle_idle();
        msg_if.valid = 1'b0;
        while (pending_tags.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    initial
    begin
        int unsigned sent;
        int unsigned len;
        cbm_msg_t    blk;
        logic [31:0] kw;

        rst_n        = 1'b0;
        msg_if.valid = 1'b0;
        msg_if.data  = '0;
        cfg_if.valid = 1'b0;
        cfg_if.data  = '0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed table
        foreach (DIRECTED_ROWS[r])
        begin
            if (DIRECTED_ROWS[r].kind == ROW_KEY)
            begin
                settle_idle();
                write_key(DIRECTED_ROWS[r].reg_idx, DIRECTED_ROWS[r].data[31:0]);
            end
            else
                send_block(cbm_msg_t'({DIRECTED_ROWS[r].data, DIRECTED_ROWS[r].last}),
                           DIRECTED_ROWS[r].known, DIRECTED_ROWS[r].known_tag);
        end

        // Random messages: three idle patterns, four key settings each
        for (int ph = 0; ph < 3; ph++)
        begin
            src_idle_pct = (ph == 0) ? 29 : (ph == 1) ? 66 : 0;
            snk_idle_pct = (ph == 0) ? 66 : (ph == 1) ? 29 : 0;
            for (int seg = 0; seg < 4; seg++)
            begin
                settle_idle();
                for (int w = 0; w < 4; w++)
                begin
                    case (seg)
                        0: kw = 32'hffff_ffff;
                        1: kw = 32'h0;
                        2: kw = (w == 3) ? ($urandom | 32'h8000_0000) : $urandom;
                        default: kw = $urandom;
                    endcase
                    write_key(KEY_REGS[w], kw);
                end
                sent = 0;
                while (sent < BLOCKS_PER_SEG)
                begin
                    len = ($urandom_range(9) == 0) ? $urandom_range(20, 8)
                                                   : $urandom_range(4, 1);
                    for (int i = 0; i < len; i++)
                    begin
                        blk = '{msg_word3: rand_word(), msg_word2: rand_word(),
                                msg_word1: rand_word(), msg_word0: rand_word(),
                                last_block: (i == len - 1)};
                        send_block(blk, 1'b0, '0);
                        sent++;
                    end
                end
            end
        end

        settle_idle();
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire

// ----- sim.f -----
rtl/core/cbm_pkg.sv
rtl/core/cbm_stream_if.sv
rtl/core/cbm_front.sv
rtl/core/cbm_fifo.sv
rtl/core/cbm_back.sv
rtl/core/chaskey_block_mac.sv
dv/chaskey_block_mac_tb.sv
